// ===== rtl/tarmw_pkg.sv =====
// ----------------------------------------------------------------------------
// tarmw_pkg
// Shared types, codes and helpers of the typed atomic read-modify-write unit.
// ----------------------------------------------------------------------------
package tarmw_pkg;

    // fixed widths set by the item fields
    localparam int unsigned CMD_W    = 4;
    localparam int unsigned INDEX_W  = 12;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned OFFSET_W = 12;
    localparam int unsigned COUNT_W  = 13;
    localparam int unsigned ADDR_W   = 15;
    localparam int unsigned ROW_W    = ADDR_W - 2;
    localparam int unsigned OLD_W    = 33;
    localparam int unsigned IN_W     = 80;
    localparam int unsigned OUT_W    = 40;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned LANES    = 4;

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // commands; values above compare-exchange behave as load
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 4'd0,
        CMD_STORE   = 4'd1,
        CMD_ADD     = 4'd2,
        CMD_SUB     = 4'd3,
        CMD_AND     = 4'd4,
        CMD_OR      = 4'd5,
        CMD_XOR     = 4'd6,
        CMD_XCHG    = 4'd7,
        CMD_CMPXCHG = 4'd8
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_BOUNDS = 2'd1,
        STAT_KIND   = 2'd2
    } status_t;

    // element kinds
    localparam logic [KIND_W-1:0] KIND_S32      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_LAST_SUP = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KIND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } back_state_t;

    // classified request as queued for the back end
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        status_t            status;
        logic [ADDR_W-1:0]  addr;
        logic [1:0]         lg_size;
        logic               is_signed;
        logic [VALUE_W-1:0] opv;
        logic [VALUE_W-1:0] cmpv;
    } rmw_item_t;

    // row of a byte bank touched by an element starting at addr
    function automatic logic [ROW_W-1:0] bank_row(input logic [ADDR_W-1:0] addr,
                                                 input logic [1:0] bank);
        logic [ROW_W-1:0] base;
        base = addr[ADDR_W-1:2];
        return base + ROW_W'(bank < addr[1:0]);
    endfunction

    // element byte lane held by a bank for an element starting at bank a0
    function automatic logic [1:0] lane_of(input logic [1:0] bank, input logic [1:0] a0);
        return 2'(bank - a0);
    endfunction

endpackage

// ===== rtl/typed_atomic_rmw_unit.sv =====
// ----------------------------------------------------------------------------
// typed_atomic_rmw_unit
// Typed atomic read-modify-write on a byte memory viewed as an element array.
//
// channel | direction | handshake          | payload
// cfg     | in        | cfg_valid/ready    | cfg_index, cfg_data
// s       | in        | s_tvalid/tready    | command, element_index, operand, compare
// m       | out       | m_tvalid/tready    | old_element, status
//
// The back end pops each request and reads the four byte banks in BK_IDLE,
// then in BK_EXEC modifies, writes back and loads the result register once
// the result register is free. After reset a clearing pass zeroes the
// memory one bank row per cycle, all MEMORY_BYTES/4 rows (rounded up), with
// s_tready low; configuration writes are taken throughout. A two-entry queue
// lets the front accept requests while the back end waits on m_tready.
// ----------------------------------------------------------------------------
module typed_atomic_rmw_unit #(
    parameter int MEMORY_BYTES = 4096
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tarmw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tarmw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // command[3:0], element_index[15:4], operand_value[47:16], compare_value[79:48]
    input  logic [tarmw_pkg::IN_W-1:0]       s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // old_element[32:0], status[34:33], zero[39:35]
    output logic [tarmw_pkg::OUT_W-1:0]      m_tdata
);
    import tarmw_pkg::*;

    logic      push_valid;
    logic      push_ready;
    rmw_item_t push_item;
    logic      pop_valid;
    logic      pop_ready;
    rmw_item_t pop_item;
    logic      clear_busy;

    // accept and classify
    tarmw_front #(
        .MEMORY_BYTES(MEMORY_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .clear_busy (clear_busy),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // decoupling queue
    tarmw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // memory and read-modify-write
    tarmw_back #(
        .MEMORY_BYTES(MEMORY_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== rtl/tarmw_front.sv =====
// ----------------------------------------------------------------------------
// tarmw_front
// Configuration registers, request acceptance and classification (status,
// byte address, element size) ahead of the queue.
// ----------------------------------------------------------------------------
module tarmw_front #(
    parameter int MEMORY_BYTES = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tarmw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tarmw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tarmw_pkg::IN_W-1:0]    s_tdata,
    input  logic                          clear_busy,
    output logic                          push_valid,
    input  logic                          push_ready,
    output tarmw_pkg::rmw_item_t          push_item
);
    import tarmw_pkg::*;

    logic [KIND_W-1:0]   kind_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic [CMD_W-1:0]    in_cmd;
    logic [INDEX_W-1:0]  in_index;
    logic [1:0]          lg_size;
    logic [ADDR_W:0]     view_end;
    logic                view_past;

    // configuration writes, taken at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg   <= KIND_S32;
            offset_reg <= '0;
            count_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_KIND:   kind_reg   <= cfg_data[KIND_W-1:0];
                CFG_OFFSET: offset_reg <= cfg_data[OFFSET_W-1:0];
                CFG_COUNT:  count_reg  <= cfg_data[COUNT_W-1:0];
                default:    ;
            endcase
        end
    end

    // request fields
    assign in_cmd   = s_tdata[3:0];
    assign in_index = s_tdata[15:4];
    assign lg_size  = kind_reg[2:1];

    // view end in bytes against memory size
    assign view_end  = (ADDR_W+1)'(offset_reg) + ((ADDR_W+1)'(count_reg) << lg_size);
    assign view_past = 32'(view_end) > 32'(MEMORY_BYTES);

    // classify
    always_comb begin
        push_item.cmd       = in_cmd;
        push_item.addr      = ADDR_W'(offset_reg) + (ADDR_W'(in_index) << lg_size);
        push_item.lg_size   = lg_size;
        push_item.is_signed = ~kind_reg[0];
        push_item.opv       = s_tdata[47:16];
        push_item.cmpv      = s_tdata[79:48];
        if (COUNT_W'(in_index) >= count_reg) begin
            push_item.status = STAT_BOUNDS;
        end else if (kind_reg > KIND_LAST_SUP) begin
            push_item.status = STAT_KIND;
        end else if (view_past) begin
            push_item.status = STAT_BOUNDS;
        end else begin
            push_item.status = STAT_OK;
        end
    end

    // no request taken during the memory clearing pass
    assign push_valid = s_tvalid & ~clear_busy;
    assign s_tready   = push_ready & ~clear_busy;

endmodule

// ===== rtl/tarmw_queue.sv =====
// ----------------------------------------------------------------------------
// tarmw_queue
// Short queue of classified requests between front and back end.
// ----------------------------------------------------------------------------
module tarmw_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  tarmw_pkg::rmw_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output tarmw_pkg::rmw_item_t pop_item
);
    import tarmw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rmw_item_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/tarmw_back.sv =====
// ----------------------------------------------------------------------------
// tarmw_back
// Byte memory in four banks, clearing pass after reset, read-modify-write of
// one element per request and the result register.
// ----------------------------------------------------------------------------
module tarmw_back #(
    parameter int MEMORY_BYTES = 4096
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  tarmw_pkg::rmw_item_t       pop_item,
    output logic                       clear_busy,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [tarmw_pkg::OUT_W-1:0] m_tdata
);
    import tarmw_pkg::*;

    localparam int ROWS = (MEMORY_BYTES + 3) / 4;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    back_state_t        state_reg, state_next;
    logic [RW-1:0]      clear_row_reg;
    rmw_item_t          item_reg;
    logic [7:0]         rd_data_reg [LANES];
    logic               m_valid_reg;
    logic [OLD_W-1:0]   old_reg;
    status_t            status_reg;

    logic               pop_go;
    logic               out_free;
    logic               finish;
    logic [RW-1:0]      rd_row [LANES];
    logic [RW-1:0]      wr_row [LANES];
    logic [7:0]         wr_byte [LANES];
    logic [LANES-1:0]   wr_en;
    logic [LANES-1:0]   exec_wr_en;
    logic [VALUE_W-1:0] old_val;
    logic [VALUE_W-1:0] new_val;
    logic [VALUE_W-1:0] wmask;
    logic               do_write;
    logic [OLD_W-1:0]   result;

    assign out_free = ~m_valid_reg | m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR: if (clear_row_reg == RW'(ROWS - 1)) state_next = BK_IDLE;
            BK_IDLE:  if (pop_valid) state_next = BK_EXEC;
            BK_EXEC:  if (out_free) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        pop_ready  = 1'b0;
        clear_busy = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            BK_CLEAR: clear_busy = 1'b1;
            BK_IDLE:  pop_ready  = 1'b1;
            BK_EXEC:  finish     = out_free;
            default:  ;
        endcase
    end

    assign pop_go = pop_valid & pop_ready;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_CLEAR;
            clear_row_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == BK_CLEAR) begin
                clear_row_reg <= clear_row_reg + 1'b1;
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request held through the modify step
    always_ff @(posedge aclk) begin
        if (pop_go) begin
            item_reg <= pop_item;
        end
    end

    // gather old element from the bank read data
    always_comb begin
        logic [1:0] bidx;
        old_val = '0;
        for (int j = 0; j < LANES; j++) begin
            bidx = 2'(item_reg.addr[1:0] + 2'(j));
            if (3'(j) < (3'd1 << item_reg.lg_size)) begin
                old_val[8*j +: 8] = rd_data_reg[bidx];
            end
        end
    end

    // modify
    always_comb begin
        case (item_reg.lg_size)
            2'd0:    wmask = 32'h0000_00FF;
            2'd1:    wmask = 32'h0000_FFFF;
            default: wmask = 32'hFFFF_FFFF;
        endcase
        do_write = item_reg.status == STAT_OK;
        case (item_reg.cmd)
            CMD_STORE:   new_val = item_reg.opv;
            CMD_ADD:     new_val = old_val + item_reg.opv;
            CMD_SUB:     new_val = old_val - item_reg.opv;
            CMD_AND:     new_val = old_val & item_reg.opv;
            CMD_OR:      new_val = old_val | item_reg.opv;
            CMD_XOR:     new_val = old_val ^ item_reg.opv;
            CMD_XCHG:    new_val = item_reg.opv;
            CMD_CMPXCHG: begin
                new_val = item_reg.opv;
                if (old_val != (item_reg.cmpv & wmask)) do_write = 1'b0;
            end
            default: begin
                new_val  = old_val;
                do_write = 1'b0;
            end
        endcase
    end

    // extended result
    always_comb begin
        logic sgn;
        sgn = item_reg.is_signed;
        if (item_reg.status != STAT_OK) begin
            result = '0;
        end else if (item_reg.cmd == CMD_STORE) begin
            result = {item_reg.opv[31], item_reg.opv};
        end else begin
            case (item_reg.lg_size)
                2'd0:    result = {{25{sgn & old_val[7]}}, old_val[7:0]};
                2'd1:    result = {{17{sgn & old_val[15]}}, old_val[15:0]};
                default: result = {sgn & old_val[31], old_val};
            endcase
        end
    end

    // bank addressing and write data
    always_comb begin
        logic [1:0] lane;
        for (int k = 0; k < LANES; k++) begin
            lane          = lane_of(2'(k), item_reg.addr[1:0]);
            rd_row[k]     = RW'(bank_row(pop_item.addr, 2'(k)));
            exec_wr_en[k] = finish & do_write & (3'(lane) < (3'd1 << item_reg.lg_size));
            if (state_reg == BK_CLEAR) begin
                wr_row[k]  = clear_row_reg;
                wr_byte[k] = '0;
                wr_en[k]   = 1'b1;
            end else begin
                wr_row[k]  = RW'(bank_row(item_reg.addr, 2'(k)));
                wr_byte[k] = new_val[{lane, 3'b000} +: 8];
                wr_en[k]   = exec_wr_en[k];
            end
        end
    end

    // byte banks, one write and one registered read each
    for (genvar k = 0; k < LANES; k++) begin : g_bank
        logic [7:0] bank_mem [ROWS];

        always_ff @(posedge aclk) begin
            if (wr_en[k]) begin
                bank_mem[wr_row[k]] <= wr_byte[k];
            end
            if (pop_go) begin
                rd_data_reg[k] <= bank_mem[rd_row[k]];
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (finish) begin
            old_reg    <= result;
            status_reg <= item_reg.status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_W - OLD_W - 2)'(0), status_reg, old_reg};

`ifndef SYNTHESIS
    a_no_pop_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_CLEAR |-> !pop_go)
        else $error("request taken during clearing pass");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg != STAT_OK) |-> old_reg == '0)
        else $error("failed request carries nonzero element");

    a_write_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_EXEC && exec_wr_en != '0) |-> item_reg.status == STAT_OK)
        else $error("memory written by failed request");

    a_exec_done: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> (state_reg == BK_IDLE && m_valid_reg))
        else $error("result not presented after modify step");
`endif

endmodule
